### sv/psev_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psev_pkg
// Shared codes and types for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package psev_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4,
    OP_POW = 3'd5
  } op_e;

  typedef struct packed {
    logic done;
    logic div0;
  } alu_status_t;

endpackage
`default_nettype wire

### sv/postfix_stack_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Evaluates postfix integer expressions on an operand stack held in memory.
//
// Channel  Dir  tdata                                  tuser / tlast
// s_axis   in   [30:0] number_value, [33:31] op_code   tuser req_type, tlast last_token
// m_axis   out  [31:0] final_value                     tuser [0] underflow, [1] overflow,
//                                                      [2] divide by zero
//
// A number token is pushed as it is accepted. An operator token pops two
// operands (POP_B, POP_A), reads the first (GET_A) and waits in CALC for the
// arithmetic unit before it pushes the result. A last token adds the final
// pop (POP_R) and the emit (EMIT). No clearing pass follows reset. The input
// stalls while a token is in work; EMIT waits until the output register is free.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [39:0] s_axis_tdata_i,   // [30:0] number_value, [33:31] op_code
  input  wire         s_axis_tuser_i,   // req_type
  input  wire         s_axis_tlast_i,   // last_token
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // final_value
  output logic [2:0]  m_axis_tuser_o    // underflow, overflow, divide by zero
);
  import psev_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP_B = 3'd1;
  localparam logic [2:0] S_POP_A = 3'd2;
  localparam logic [2:0] S_GET_A = 3'd3;
  localparam logic [2:0] S_CALC  = 3'd4;
  localparam logic [2:0] S_POP_R = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam logic REQ_NUMBER = 1'b0;

  logic [2:0]            state_q;
  logic [CW-1:0]         count_q;
  logic                  under_q, over_q, div0_q;
  logic                  pop_empty_q;
  logic [2:0]            op_q;
  logic                  last_q;
  logic [DATA_WIDTH-1:0] b_q;
  logic                  m_valid_q;
  logic [31:0]           m_data_q;
  logic [2:0]            m_user_q;

  logic                  accept, is_empty, is_full, pop_now, push_now;
  logic [DATA_WIDTH-1:0] push_val, rdata, pop_val;
  logic [DATA_WIDTH+30:0] num_ext;
  logic [DATA_WIDTH+31:0] out_ext;
  logic                  alu_start;
  logic [DATA_WIDTH-1:0] alu_res;
  alu_status_t           alu_st;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CW'(STACK_DEPTH));
  assign pop_now  = (state_q == S_POP_B) || (state_q == S_POP_A) || (state_q == S_POP_R);
  assign push_now = (accept && (s_axis_tuser_i == REQ_NUMBER))
                 || ((state_q == S_CALC) && alu_st.done);
  assign num_ext  = {{DATA_WIDTH{1'b0}}, s_axis_tdata_i[30:0]};
  assign push_val = (state_q == S_CALC) ? alu_res : num_ext[DATA_WIDTH-1:0];
  assign pop_val  = pop_empty_q ? '0 : rdata;
  assign out_ext  = {{32{pop_val[DATA_WIDTH-1]}}, pop_val};
  assign alu_start = (state_q == S_GET_A);

  psev_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_now && !is_full),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (push_val),
    .re_i    (pop_now && !is_empty),
    .raddr_i (AW'(count_q - CW'(1))),
    .rdata_o (rdata)
  );

  psev_alu #(
    .WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (alu_start),
    .op_i     (op_q),
    .a_i      (pop_val),
    .b_i      (b_q),
    .result_o (alu_res),
    .status_o (alu_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      under_q     <= 1'b0;
      over_q      <= 1'b0;
      div0_q      <= 1'b0;
      pop_empty_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (push_now) begin
        if (is_full) begin
          over_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
        end
      end
      if (pop_now) begin
        pop_empty_q <= is_empty;
        if (is_empty) begin
          under_q <= 1'b1;
        end else begin
          count_q <= count_q - CW'(1);
        end
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q   <= s_axis_tdata_i[33:31];
            last_q <= s_axis_tlast_i;
            if (s_axis_tuser_i == REQ_NUMBER) begin
              state_q <= s_axis_tlast_i ? S_POP_R : S_IDLE;
            end else begin
              state_q <= S_POP_B;
            end
          end
        end
        S_POP_B: state_q <= S_POP_A;
        S_POP_A: begin
          b_q     <= pop_val;
          state_q <= S_GET_A;
        end
        S_GET_A: state_q <= S_CALC;
        S_CALC: begin
          if (alu_st.done) begin
            if (alu_st.div0) begin
              div0_q <= 1'b1;
            end
            state_q <= last_q ? S_POP_R : S_IDLE;
          end
        end
        S_POP_R: state_q <= S_EMIT;
        S_EMIT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= out_ext[31:0];
            m_user_q  <= {div0_q, over_q, under_q};
            count_q   <= '0;
            under_q   <= 1'b0;
            over_q    <= 1'b0;
            div0_q    <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  logic unused_pad;
  assign unused_pad = ^s_axis_tdata_i[39:34];

endmodule
`default_nettype wire

### sv/psev_stack_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psev_stack_ram
// Operand stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module psev_stack_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### sv/psev_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psev_alu
// Multi-cycle arithmetic unit: add and subtract in one step, multiply by
// byte-serial partial products, restoring divide, and square-and-multiply power.
// ----------------------------------------------------------------------------
module psev_alu #(
  parameter int unsigned WIDTH = 32
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  wire  [2:0]               op_i,
  input  wire  [WIDTH-1:0]         a_i,
  input  wire  [WIDTH-1:0]         b_i,
  output logic [WIDTH-1:0]         result_o,
  output psev_pkg::alu_status_t    status_o
);
  import psev_pkg::*;

  localparam int unsigned NCH = (WIDTH + 7) / 8;
  localparam int unsigned CHW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned BW  = $clog2(WIDTH);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;
  localparam logic [1:0] M_PWR  = 2'd3;

  logic [1:0]       mode_q;
  logic             done_q, div0_q;
  logic [WIDTH-1:0] res_q;
  logic [CHW-1:0]   chunk_q;
  logic [BW-1:0]    bit_q;
  logic [WIDTH-1:0] m1x_q, m1y_q, m2x_q, m2y_q, p1_q, p2_q;
  logic [WIDTH-1:0] acc_q, exp_q;
  logic [WIDTH-1:0] rem_q, quo_q, dvs_q;
  logic             neg_q, is_div_q;

  logic [WIDTH+7:0] prod1, prod2;
  logic [WIDTH-1:0] p1_sum, p2_sum, acc_nx;
  logic [WIDTH:0]   rem_sh;
  logic             rem_ge;
  logic [WIDTH-1:0] rem_nx, quo_nx, mag_a, mag_b;
  logic             neg_a, neg_b;
  logic [WIDTH-1:0] all_ones;

  assign all_ones = '1;
  assign neg_a = a_i[WIDTH-1];
  assign neg_b = b_i[WIDTH-1];
  assign mag_a = neg_a ? (~a_i + WIDTH'(1)) : a_i;
  assign mag_b = neg_b ? (~b_i + WIDTH'(1)) : b_i;

  assign prod1  = {8'd0, m1x_q} * {{WIDTH{1'b0}}, m1y_q[7:0]};
  assign prod2  = {8'd0, m2x_q} * {{WIDTH{1'b0}}, m2y_q[7:0]};
  assign p1_sum = p1_q + prod1[WIDTH-1:0];
  assign p2_sum = p2_q + prod2[WIDTH-1:0];
  assign acc_nx = exp_q[0] ? p1_sum : acc_q;

  assign rem_sh = {rem_q, quo_q[WIDTH-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = rem_ge ? WIDTH'(rem_sh - {1'b0, dvs_q}) : rem_sh[WIDTH-1:0];
  assign quo_nx = {quo_q[WIDTH-2:0], rem_ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      done_q <= 1'b0;
      div0_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (mode_q)
        M_IDLE: begin
          if (start_i) begin
            div0_q <= 1'b0;
            case (op_i)
              OP_ADD: begin
                res_q  <= a_i + b_i;
                done_q <= 1'b1;
              end
              OP_SUB: begin
                res_q  <= a_i - b_i;
                done_q <= 1'b1;
              end
              OP_MUL: begin
                m1x_q   <= a_i;
                m1y_q   <= b_i;
                p1_q    <= '0;
                chunk_q <= CHW'(NCH - 1);
                mode_q  <= M_MUL;
              end
              OP_DIV, OP_REM: begin
                if (b_i == '0) begin
                  res_q  <= '0;
                  div0_q <= 1'b1;
                  done_q <= 1'b1;
                end else begin
                  rem_q    <= '0;
                  quo_q    <= mag_a;
                  dvs_q    <= mag_b;
                  is_div_q <= (op_i == OP_DIV);
                  neg_q    <= (op_i == OP_DIV) ? (neg_a ^ neg_b) : neg_a;
                  bit_q    <= BW'(WIDTH - 1);
                  mode_q   <= M_DIV;
                end
              end
              OP_POW: begin
                if (neg_b) begin
                  done_q <= 1'b1;
                  if (a_i == WIDTH'(1)) begin
                    res_q <= WIDTH'(1);
                  end else if (a_i == all_ones) begin
                    res_q <= b_i[0] ? all_ones : WIDTH'(1);
                  end else begin
                    res_q  <= '0;
                    div0_q <= (a_i == '0);
                  end
                end else begin
                  acc_q   <= WIDTH'(1);
                  exp_q   <= b_i;
                  m1x_q   <= WIDTH'(1);
                  m1y_q   <= a_i;
                  m2x_q   <= a_i;
                  m2y_q   <= a_i;
                  p1_q    <= '0;
                  p2_q    <= '0;
                  chunk_q <= CHW'(NCH - 1);
                  bit_q   <= BW'(WIDTH - 1);
                  mode_q  <= M_PWR;
                end
              end
              default: begin
                res_q  <= '0;
                done_q <= 1'b1;
              end
            endcase
          end
        end
        M_MUL: begin
          p1_q  <= p1_sum;
          m1x_q <= m1x_q << 8;
          m1y_q <= m1y_q >> 8;
          if (chunk_q == '0) begin
            res_q  <= p1_sum;
            done_q <= 1'b1;
            mode_q <= M_IDLE;
          end else begin
            chunk_q <= chunk_q - CHW'(1);
          end
        end
        M_DIV: begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          if (bit_q == '0) begin
            if (is_div_q) begin
              res_q <= neg_q ? (~quo_nx + WIDTH'(1)) : quo_nx;
            end else begin
              res_q <= neg_q ? (~rem_nx + WIDTH'(1)) : rem_nx;
            end
            done_q <= 1'b1;
            mode_q <= M_IDLE;
          end else begin
            bit_q <= bit_q - BW'(1);
          end
        end
        M_PWR: begin
          if (chunk_q == '0) begin
            acc_q   <= acc_nx;
            exp_q   <= exp_q >> 1;
            m1x_q   <= acc_nx;
            m1y_q   <= p2_sum;
            m2x_q   <= p2_sum;
            m2y_q   <= p2_sum;
            p1_q    <= '0;
            p2_q    <= '0;
            chunk_q <= CHW'(NCH - 1);
            if (bit_q == '0) begin
              res_q  <= acc_nx;
              done_q <= 1'b1;
              mode_q <= M_IDLE;
            end else begin
              bit_q <= bit_q - BW'(1);
            end
          end else begin
            p1_q    <= p1_sum;
            p2_q    <= p2_sum;
            m1x_q   <= m1x_q << 8;
            m1y_q   <= m1y_q >> 8;
            m2x_q   <= m2x_q << 8;
            m2y_q   <= m2y_q >> 8;
            chunk_q <= chunk_q - CHW'(1);
          end
        end
        default: mode_q <= M_IDLE;
      endcase
    end
  end

  assign result_o      = res_q;
  assign status_o.done = done_q;
  assign status_o.div0 = div0_q;

endmodule
`default_nettype wire
